// ===== src/cir_pkg.sv =====
// ----------------------------------------------------------------------------
// cir_pkg
// Shared types, codes and constants of the contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int BODY_COUNT_DEF = 64;
  localparam int DIV_DVD_W      = 56;
  localparam int DIV_DVS_W      = 32;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_CONTACT = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_SKIP = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic [16:0] RESTITUTION_RST = 17'd6554;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [5:0]         index_a;
    logic [5:0]         index_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        inv_mass;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [31:0]        contact_normal;
    logic [31:0]        penetration_dt;
  } cir_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic [1:0]         status;
  } cir_out_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        imass;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
  } cir_body_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH, ST_LOAD, ST_RDA, ST_CAPA, ST_RDB, ST_CAPB, ST_CHK,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9, ST_M10,
    ST_DIVI, ST_DIVI_W, ST_IMP, ST_DIVP, ST_DIVP_W, ST_PUSH,
    ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_COPY, ST_WRA, ST_WRB, ST_DONE
  } cir_state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH, OP_SKIP, OP_LOAD, OP_RD_A, OP_CAP_A, OP_RD_B, OP_CAP_B,
    OP_CHK, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9,
    OP_M10, OP_DIVI, OP_IMP, OP_DIVP, OP_PUSH, OP_U1, OP_U2, OP_U3, OP_U4,
    OP_U5, OP_COPY, OP_WR_A, OP_WR_B, OP_EMIT
  } cir_op_t;

  typedef struct packed {
    cir_op_t    op;
    logic [1:0] grp;   // bit 0: push rather than impulse, bit 1: body b
  } cir_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       a_ok;
    logic       b_ok;
    logic       denom_zero;
    logic       div_busy;
  } cir_sts_t;

endpackage

// ===== src/cir_if.sv =====
// ----------------------------------------------------------------------------
// cir_in_if / cir_out_if
// Valid/ready channels carrying contact requests and their results.
// ----------------------------------------------------------------------------
interface cir_in_if;
  logic             valid;
  logic             ready;
  cir_pkg::cir_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cir_out_if;
  logic              valid;
  logic              ready;
  cir_pkg::cir_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cir_ram.sv =====
// ----------------------------------------------------------------------------
// cir_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cir_div.sv =====
// ----------------------------------------------------------------------------
// cir_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cir_div #(
  parameter int DVD_W = cir_pkg::DIV_DVD_W,
  parameter int DVS_W = cir_pkg::DIV_DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits DVS_W bits
      rem      <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

// ===== src/cir_ctrl.sv =====
// ----------------------------------------------------------------------------
// cir_ctrl
// Sequencer: steps the datapath through load, read and contact resolution.
// ----------------------------------------------------------------------------
module cir_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  cir_pkg::cir_sts_t   sts,
  output cir_pkg::cir_cmd_t   cmd
);

  cir_pkg::cir_state_t state, state_next;
  logic [1:0]          grp, grp_next;
  logic                out_free;
  logic                emit;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == cir_pkg::ST_IDLE);
  assign emit     = (cmd.op == cir_pkg::OP_EMIT);

  always_comb begin
    state_next = state;
    case (state)
      cir_pkg::ST_IDLE:     if (in_valid) state_next = cir_pkg::ST_DISPATCH;
      cir_pkg::ST_DISPATCH: begin
        case (sts.cmd)
          cir_pkg::CMD_LOAD:
            state_next = sts.a_ok ? cir_pkg::ST_LOAD : cir_pkg::ST_DONE;
          cir_pkg::CMD_READ:
            state_next = sts.a_ok ? cir_pkg::ST_RDA : cir_pkg::ST_DONE;
          cir_pkg::CMD_CONTACT:
            state_next = (sts.a_ok && sts.b_ok) ? cir_pkg::ST_RDA : cir_pkg::ST_DONE;
          default: state_next = cir_pkg::ST_DONE;
        endcase
      end
      cir_pkg::ST_LOAD:   state_next = cir_pkg::ST_DONE;
      cir_pkg::ST_RDA:
        state_next = (sts.cmd == cir_pkg::CMD_CONTACT) ? cir_pkg::ST_RDB : cir_pkg::ST_CAPA;
      cir_pkg::ST_CAPA:   state_next = cir_pkg::ST_DONE;
      cir_pkg::ST_RDB:    state_next = cir_pkg::ST_CAPB;
      cir_pkg::ST_CAPB:   state_next = cir_pkg::ST_CHK;
      cir_pkg::ST_CHK:
        state_next = sts.denom_zero ? cir_pkg::ST_DONE : cir_pkg::ST_M1;
      cir_pkg::ST_M1:     state_next = cir_pkg::ST_M2;
      cir_pkg::ST_M2:     state_next = cir_pkg::ST_M3;
      cir_pkg::ST_M3:     state_next = cir_pkg::ST_M4;
      cir_pkg::ST_M4:     state_next = cir_pkg::ST_M5;
      cir_pkg::ST_M5:     state_next = cir_pkg::ST_M6;
      cir_pkg::ST_M6:     state_next = cir_pkg::ST_M7;
      cir_pkg::ST_M7:     state_next = cir_pkg::ST_M8;
      cir_pkg::ST_M8:     state_next = cir_pkg::ST_M9;
      cir_pkg::ST_M9:     state_next = cir_pkg::ST_M10;
      cir_pkg::ST_M10:    state_next = cir_pkg::ST_DIVI;
      cir_pkg::ST_DIVI:   state_next = cir_pkg::ST_DIVI_W;
      cir_pkg::ST_DIVI_W: if (!sts.div_busy) state_next = cir_pkg::ST_IMP;
      cir_pkg::ST_IMP:    state_next = cir_pkg::ST_DIVP;
      cir_pkg::ST_DIVP:   state_next = cir_pkg::ST_DIVP_W;
      cir_pkg::ST_DIVP_W: if (!sts.div_busy) state_next = cir_pkg::ST_PUSH;
      cir_pkg::ST_PUSH:   state_next = cir_pkg::ST_U1;
      cir_pkg::ST_U1:     state_next = cir_pkg::ST_U2;
      cir_pkg::ST_U2:     state_next = cir_pkg::ST_U3;
      cir_pkg::ST_U3:     state_next = cir_pkg::ST_U4;
      cir_pkg::ST_U4:     state_next = cir_pkg::ST_U5;
      cir_pkg::ST_U5: begin
        if (grp == 2'd3) begin
          state_next = cir_pkg::ST_WRA;
        end else if (grp == 2'd1) begin
          state_next = cir_pkg::ST_COPY;
        end else begin
          state_next = cir_pkg::ST_U1;
        end
      end
      cir_pkg::ST_COPY:   state_next = cir_pkg::ST_U1;
      cir_pkg::ST_WRA:    state_next = cir_pkg::ST_WRB;
      cir_pkg::ST_WRB:    state_next = cir_pkg::ST_DONE;
      cir_pkg::ST_DONE:   if (out_free) state_next = cir_pkg::ST_IDLE;
      default:            state_next = cir_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.grp = grp;
    cmd.op  = cir_pkg::OP_NONE;
    case (state)
      cir_pkg::ST_IDLE:     if (in_valid) cmd.op = cir_pkg::OP_LATCH;
      cir_pkg::ST_DISPATCH: begin
        if (sts.cmd == cir_pkg::CMD_CONTACT && !(sts.a_ok && sts.b_ok)) begin
          cmd.op = cir_pkg::OP_SKIP;
        end
      end
      cir_pkg::ST_LOAD:   cmd.op = cir_pkg::OP_LOAD;
      cir_pkg::ST_RDA:    cmd.op = cir_pkg::OP_RD_A;
      cir_pkg::ST_CAPA:   cmd.op = cir_pkg::OP_CAP_A;
      cir_pkg::ST_RDB:    cmd.op = cir_pkg::OP_RD_B;
      cir_pkg::ST_CAPB:   cmd.op = cir_pkg::OP_CAP_B;
      cir_pkg::ST_CHK:    cmd.op = cir_pkg::OP_CHK;
      cir_pkg::ST_M1:     cmd.op = cir_pkg::OP_M1;
      cir_pkg::ST_M2:     cmd.op = cir_pkg::OP_M2;
      cir_pkg::ST_M3:     cmd.op = cir_pkg::OP_M3;
      cir_pkg::ST_M4:     cmd.op = cir_pkg::OP_M4;
      cir_pkg::ST_M5:     cmd.op = cir_pkg::OP_M5;
      cir_pkg::ST_M6:     cmd.op = cir_pkg::OP_M6;
      cir_pkg::ST_M7:     cmd.op = cir_pkg::OP_M7;
      cir_pkg::ST_M8:     cmd.op = cir_pkg::OP_M8;
      cir_pkg::ST_M9:     cmd.op = cir_pkg::OP_M9;
      cir_pkg::ST_M10:    cmd.op = cir_pkg::OP_M10;
      cir_pkg::ST_DIVI:   cmd.op = cir_pkg::OP_DIVI;
      cir_pkg::ST_IMP:    cmd.op = cir_pkg::OP_IMP;
      cir_pkg::ST_DIVP:   cmd.op = cir_pkg::OP_DIVP;
      cir_pkg::ST_PUSH:   cmd.op = cir_pkg::OP_PUSH;
      cir_pkg::ST_U1:     cmd.op = cir_pkg::OP_U1;
      cir_pkg::ST_U2:     cmd.op = cir_pkg::OP_U2;
      cir_pkg::ST_U3:     cmd.op = cir_pkg::OP_U3;
      cir_pkg::ST_U4:     cmd.op = cir_pkg::OP_U4;
      cir_pkg::ST_U5:     cmd.op = cir_pkg::OP_U5;
      cir_pkg::ST_COPY:   cmd.op = cir_pkg::OP_COPY;
      cir_pkg::ST_WRA:    cmd.op = cir_pkg::OP_WR_A;
      cir_pkg::ST_WRB:    cmd.op = cir_pkg::OP_WR_B;
      cir_pkg::ST_DONE:   if (out_free) cmd.op = cir_pkg::OP_EMIT;
      default:            cmd.op = cir_pkg::OP_NONE;
    endcase
  end

  assign grp_next = (state == cir_pkg::ST_U5) ? grp + 2'd1 : grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cir_pkg::ST_IDLE;
      grp       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      grp       <= grp_next;
      out_valid <= emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result emitted over an untaken result");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == cir_pkg::OP_DIVI || cmd.op == cir_pkg::OP_DIVP) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == cir_pkg::ST_DISPATCH))
    else $error("accepted request not dispatched");

  a_grp_zero: assert property (@(posedge clk) disable iff (rst)
    (state == cir_pkg::ST_CHK) |-> (grp == 2'd0))
    else $error("update group not at start");

endmodule

// ===== src/cir_dp.sv =====
// ----------------------------------------------------------------------------
// cir_dp
// Datapath: body table, shared multipliers, divider and result register.
// ----------------------------------------------------------------------------
module cir_dp #(
  parameter int BODY_COUNT = cir_pkg::BODY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cir_pkg::cir_cmd_t  cmd,
  output cir_pkg::cir_sts_t  sts,
  input  cir_pkg::cir_in_t   item_data,
  input  logic [16:0]        restitution,
  output cir_pkg::cir_out_t  res
);

  localparam int ADDR_W = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
  localparam int BODY_W = $bits(cir_pkg::cir_body_t);
  localparam int DVD_W  = cir_pkg::DIV_DVD_W;
  localparam int DVS_W  = cir_pkg::DIV_DVS_W;
  localparam logic signed [65:0] MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] MIN66 = -66'sd2147483648;
  localparam logic [DVD_W-1:0]   QMAXP = DVD_W'(64'd2147483647);
  localparam logic [DVD_W-1:0]   QMAXN = DVD_W'(64'd2147483648);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > MAX66) begin
      return 32'sh7FFFFFFF;
    end else if (v < MIN66) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > MAX66) || (v < MIN66);
  endfunction

  cir_pkg::cir_in_t   it;
  cir_pkg::cir_body_t ra, rb, ld_body, cur_body, upd_body;
  logic [ADDR_W-1:0]  addr_a, addr_b, raddr, waddr;
  logic               we;
  logic [BODY_W-1:0]  wdata, rdata;
  cir_pkg::cir_body_t rd_body;

  logic signed [15:0] nx, ny;
  logic [15:0]        depth, dt;
  logic [31:0]        denom;
  logic signed [65:0] prod, acc;
  logic signed [47:0] sep, rx, ry, accsep, bounce, numer, tq;
  logic               neg, skip, sat;
  logic signed [31:0] impq, pushq;

  logic signed [47:0] mw_a;
  logic signed [17:0] mw_b;
  logic signed [65:0] mw_p;
  logic signed [31:0] ms_a, ms_b;
  logic signed [63:0] ms_p;
  logic signed [65:0] sum_t, diff_t, delta, upd_sum;
  logic signed [48:0] bdiff;
  logic signed [47:0] bounce_next;
  logic signed [47:0] numer_abs;
  logic signed [31:0] cur_val, new_val;
  logic               upd_ovf, y_axis;

  logic             div_start, div_busy;
  logic [DVD_W-1:0] div_dvd, div_q;

  assign addr_a  = ADDR_W'(it.index_a);
  assign addr_b  = ADDR_W'(it.index_b);
  assign nx      = it.contact_normal[15:0];
  assign ny      = it.contact_normal[31:16];
  assign depth   = it.penetration_dt[15:0];
  assign dt      = it.penetration_dt[31:16];
  assign rd_body = cir_pkg::cir_body_t'(rdata);

  assign sts.cmd        = it.cmd;
  assign sts.a_ok       = 32'(it.index_a) < 32'(BODY_COUNT);
  assign sts.b_ok       = 32'(it.index_b) < 32'(BODY_COUNT);
  assign sts.denom_zero = (ra.imass == '0) && (rb.imass == '0);
  assign sts.div_busy   = div_busy;

  // body table
  always_comb begin
    ld_body.px    = it.pos_x;
    ld_body.py    = it.pos_y;
    ld_body.vx    = it.vel_x;
    ld_body.vy    = it.vel_y;
    ld_body.imass = it.inv_mass;
    ld_body.ax    = it.acc_x;
    ld_body.ay    = it.acc_y;
  end

  assign we    = (cmd.op == cir_pkg::OP_LOAD) || (cmd.op == cir_pkg::OP_WR_A) ||
                 (cmd.op == cir_pkg::OP_WR_B);
  assign waddr = (cmd.op == cir_pkg::OP_WR_B) ? addr_b : addr_a;
  assign raddr = (cmd.op == cir_pkg::OP_RD_B) ? addr_b : addr_a;
  assign wdata = (cmd.op == cir_pkg::OP_LOAD) ? BODY_W'(ld_body) :
                 (cmd.op == cir_pkg::OP_WR_A) ? BODY_W'(ra) : BODY_W'(rb);

  cir_ram #(
    .WIDTH (BODY_W),
    .DEPTH (BODY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared multiplier operands
  always_comb begin
    mw_a = '0;
    mw_b = '0;
    case (cmd.op)
      cir_pkg::OP_M1: begin
        mw_a = 48'(rb.vx) - 48'(ra.vx);
        mw_b = 18'(nx);
      end
      cir_pkg::OP_M2: begin
        mw_a = 48'(rb.vy) - 48'(ra.vy);
        mw_b = 18'(ny);
      end
      cir_pkg::OP_M3: begin
        mw_a = 48'(rb.ax) - 48'(ra.ax);
        mw_b = {2'b00, dt};
      end
      cir_pkg::OP_M4: begin
        mw_a = 48'(rb.ay) - 48'(ra.ay);
        mw_b = {2'b00, dt};
      end
      cir_pkg::OP_M5: begin
        mw_a = rx;
        mw_b = 18'(nx);
      end
      cir_pkg::OP_M6: begin
        mw_a = ry;
        mw_b = 18'(ny);
      end
      cir_pkg::OP_M9: begin
        mw_a = bounce;
        mw_b = {1'b0, restitution};
      end
      cir_pkg::OP_U3: begin
        mw_a = tq;
        mw_b = 18'(nx);
      end
      cir_pkg::OP_U4: begin
        mw_a = tq;
        mw_b = 18'(ny);
      end
      default: begin
        mw_a = '0;
        mw_b = '0;
      end
    endcase
  end

  assign mw_p = mw_a * mw_b;
  assign ms_a = cmd.grp[0] ? pushq : impq;
  assign ms_b = {1'b0, (cmd.grp[1] ? rb.imass : ra.imass)};
  assign ms_p = ms_a * ms_b;

  assign sum_t  = (acc + prod) >>> 14;
  assign diff_t = -66'(sep) - (prod >>> 16);
  assign bdiff  = 49'(sep) - 49'(accsep);

  always_comb begin
    bounce_next = sep;
    if (accsep > 48'sd0) begin
      bounce_next = (bdiff < 49'sd0) ? 48'sd0 : bdiff[47:0];
    end
  end

  assign numer_abs = (numer < 48'sd0) ? -numer : numer;

  // velocity or position update of one axis of one body
  assign y_axis   = (cmd.op == cir_pkg::OP_U5);
  assign cur_body = cmd.grp[1] ? rb : ra;
  always_comb begin
    case ({cmd.grp[0], y_axis})
      2'b00:   cur_val = cur_body.vx;
      2'b01:   cur_val = cur_body.vy;
      2'b10:   cur_val = cur_body.px;
      2'b11:   cur_val = cur_body.py;
      default: cur_val = cur_body.vx;
    endcase
  end

  assign delta   = prod >>> 14;
  // velocity of a and position of b move against the normal
  assign upd_sum = (cmd.grp[0] == cmd.grp[1]) ? 66'(cur_val) - delta
                                              : 66'(cur_val) + delta;
  assign new_val = sat32(upd_sum);
  assign upd_ovf = ovf32(upd_sum);

  always_comb begin
    upd_body = cur_body;
    case ({cmd.grp[0], y_axis})
      2'b00:   upd_body.vx = new_val;
      2'b01:   upd_body.vy = new_val;
      2'b10:   upd_body.px = new_val;
      2'b11:   upd_body.py = new_val;
      default: upd_body.vx = new_val;
    endcase
  end

  // divider shared by the impulse and the push
  assign div_start = (cmd.op == cir_pkg::OP_DIVI) || (cmd.op == cir_pkg::OP_DIVP);
  assign div_dvd   = (cmd.op == cir_pkg::OP_DIVI) ?
                     DVD_W'({numer_abs[39:0], 16'b0}) : DVD_W'({depth, 24'b0});

  cir_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (denom),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= 1'b0;
      sat  <= 1'b0;
    end else begin
      case (cmd.op)
        cir_pkg::OP_LATCH: begin
          skip <= 1'b0;
          sat  <= 1'b0;
        end
        cir_pkg::OP_SKIP: skip <= 1'b1;
        cir_pkg::OP_CHK:  if (sts.denom_zero) skip <= 1'b1;
        cir_pkg::OP_IMP: begin
          if (neg ? (div_q > QMAXN) : (div_q > QMAXP)) sat <= 1'b1;
        end
        cir_pkg::OP_PUSH: if (div_q > QMAXP) sat <= 1'b1;
        cir_pkg::OP_U4, cir_pkg::OP_U5: if (upd_ovf) sat <= 1'b1;
        default: sat <= sat;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      cir_pkg::OP_LATCH: it <= item_data;
      cir_pkg::OP_CAP_A: ra <= rd_body;
      cir_pkg::OP_RD_B:  ra <= rd_body;
      cir_pkg::OP_CAP_B: rb <= rd_body;
      cir_pkg::OP_CHK:   denom <= {1'b0, ra.imass} + {1'b0, rb.imass};
      cir_pkg::OP_M1:    prod <= mw_p;
      cir_pkg::OP_M2: begin
        acc  <= prod;
        prod <= mw_p;
      end
      cir_pkg::OP_M3: begin
        sep  <= sum_t[47:0];
        prod <= mw_p;
      end
      cir_pkg::OP_M4: begin
        rx   <= 48'(prod >>> 8);
        prod <= mw_p;
      end
      cir_pkg::OP_M5: begin
        ry   <= 48'(prod >>> 8);
        prod <= mw_p;
      end
      cir_pkg::OP_M6: begin
        acc  <= prod;
        prod <= mw_p;
      end
      cir_pkg::OP_M7:    accsep <= sum_t[47:0];
      cir_pkg::OP_M8:    bounce <= bounce_next;
      cir_pkg::OP_M9:    prod <= mw_p;
      cir_pkg::OP_M10:   numer <= diff_t[47:0];
      cir_pkg::OP_DIVI:  neg <= (numer < 48'sd0);
      cir_pkg::OP_IMP: begin
        if (neg) begin
          impq <= (div_q > QMAXN) ? 32'sh80000000 : 32'(~div_q[31:0] + 32'd1);
        end else begin
          impq <= (div_q > QMAXP) ? 32'sh7FFFFFFF : div_q[31:0];
        end
      end
      cir_pkg::OP_PUSH:  pushq <= (div_q > QMAXP) ? 32'sh7FFFFFFF : div_q[31:0];
      cir_pkg::OP_U1:    prod <= 66'(ms_p);
      cir_pkg::OP_U2:    tq <= 48'(prod >>> 16);
      cir_pkg::OP_U3:    prod <= mw_p;
      cir_pkg::OP_U4: begin
        prod <= mw_p;
        if (cmd.grp[1]) rb <= upd_body;
        else            ra <= upd_body;
      end
      cir_pkg::OP_U5: begin
        if (cmd.grp[1]) rb <= upd_body;
        else            ra <= upd_body;
      end
      // same body twice: b starts from the values a has just taken
      cir_pkg::OP_COPY:  if (it.index_a == it.index_b) rb <= ra;
      cir_pkg::OP_EMIT: begin
        if (it.cmd == cir_pkg::CMD_READ && sts.a_ok) begin
          res.out_pos_x <= ra.px;
          res.out_pos_y <= ra.py;
          res.out_vel_x <= ra.vx;
          res.out_vel_y <= ra.vy;
        end else begin
          res.out_pos_x <= '0;
          res.out_pos_y <= '0;
          res.out_vel_x <= '0;
          res.out_vel_y <= '0;
        end
        res.status <= skip ? cir_pkg::STAT_SKIP :
                      (sat ? cir_pkg::STAT_SAT : cir_pkg::STAT_DONE);
      end
      default: prod <= prod;
    endcase
  end

endmodule

// ===== src/contact_impulse_resolver.sv =====
// Load and read requests pass through dispatch and a table access to a registered result;
// a contact runs the divider twice (a 56-bit quotient each), plus 10 multiply steps,
// 21 update steps and the table accesses.
// Throughput: one request at a time; the next is taken the cycle after a result is
// registered, while that result may still wait to be taken.
// Reset clears the sequencer and sets restitution to 6554; the table is undefined until loaded.
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// Impulse-based contact resolution over a table of 2D bodies.
// ----------------------------------------------------------------------------
module contact_impulse_resolver #(
  parameter int BODY_COUNT = cir_pkg::BODY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cir_in_if.sink      item,
  cir_out_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0]       restitution;
  cir_pkg::cir_cmd_t cmd;
  cir_pkg::cir_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {15'b0, restitution} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= cir_pkg::RESTITUTION_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      restitution <= pwdata[16:0];
    end
  end

  cir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  cir_dp #(
    .BODY_COUNT (BODY_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item_data   (item.data),
    .restitution (restitution),
    .res         (result.data)
  );

endmodule
